FILE: rtl/rct_pkg.sv
// Shared types and constants of the route connection table.
// Used by every module of the block; depends on nothing.
package rct_pkg;

    localparam int SLOTS           = 64;
    localparam int SLOT_W          = $clog2(SLOTS);
    localparam int CNT_W           = $clog2(SLOTS + 1);
    localparam int CHAIN_COUNT     = 16;
    localparam int NODES_PER_CHAIN = 16;
    localparam int MAX_OUT         = 64;
    localparam int QDEPTH          = 2;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_INVALID  = 3'd2,
        ST_FULL     = 3'd3,
        ST_REMOVED  = 3'd4,
        ST_IGNORED  = 3'd5,
        ST_LISTED   = 3'd6,
        ST_EMPTY    = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        K_ADD      = 2'd0,
        K_REMOVE   = 2'd1,
        K_LIST_SRC = 2'd2,
        K_LIST_DST = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_ADD_BAD,
        OP_REMOVE,
        OP_LIST_SRC,
        OP_LIST_DST,
        OP_LIST_NONE
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [3:0]         sc;
        logic [3:0]         sn;
        logic [3:0]         dc;
        logic [3:0]         dn;
        logic signed [15:0] w;
        logic [7:0]         ty;
    } t_entry;

    typedef struct packed {
        t_op         op;
        t_entry      ent;
        logic [5:0]  idx;
        logic [3:0]  qc;
        logic [6:0]  lim;
    } t_cmd;

    typedef struct packed {
        logic        vld;
        t_status     status;
        logic [5:0]  slot;
        t_entry      ent;
        logic [6:0]  active;
        logic        last;
    } t_result;

endpackage

FILE: rtl/rct_front.sv
// Command front end: checks endpoints, saturates the list limit and
// classifies each accepted beat into an operation. Depends on rct_pkg.
module rct_front (
    input  logic               i_start,
    input  logic               i_full,
    input  logic [1:0]         i_kind,
    input  logic [3:0]         i_src_chain,
    input  logic [3:0]         i_src_node,
    input  logic [3:0]         i_dst_chain,
    input  logic [3:0]         i_dst_node,
    input  logic signed [15:0] i_route_weight,
    input  logic [7:0]         i_type_id,
    input  logic               i_endpoints_ok,
    input  logic [5:0]         i_route_index,
    input  logic [3:0]         i_query_chain,
    input  logic [6:0]         i_list_limit,
    output logic               o_push,
    output rct_pkg::t_cmd      o_cmd
);

    logic       ep_ok;
    logic [6:0] lim;

    assign ep_ok = i_endpoints_ok
        && ({1'b0, i_src_chain} < 5'(rct_pkg::CHAIN_COUNT))
        && ({1'b0, i_dst_chain} < 5'(rct_pkg::CHAIN_COUNT))
        && ({1'b0, i_src_node}  < 5'(rct_pkg::NODES_PER_CHAIN))
        && ({1'b0, i_dst_node}  < 5'(rct_pkg::NODES_PER_CHAIN));

    assign lim = (i_list_limit > 7'(rct_pkg::MAX_OUT)) ? 7'(rct_pkg::MAX_OUT) : i_list_limit;

    assign o_push = i_start & ~i_full;

    always_comb begin
        o_cmd        = '0;
        o_cmd.ent.sc = i_src_chain;
        o_cmd.ent.sn = i_src_node;
        o_cmd.ent.dc = i_dst_chain;
        o_cmd.ent.dn = i_dst_node;
        o_cmd.ent.w  = i_route_weight;
        o_cmd.ent.ty = i_type_id;
        o_cmd.idx    = i_route_index;
        o_cmd.qc     = i_query_chain;
        o_cmd.lim    = lim;
        unique case (rct_pkg::t_kind'(i_kind))
            rct_pkg::K_ADD: begin
                o_cmd.op = ep_ok ? rct_pkg::OP_ADD : rct_pkg::OP_ADD_BAD;
            end
            rct_pkg::K_REMOVE: begin
                o_cmd.op = rct_pkg::OP_REMOVE;
            end
            rct_pkg::K_LIST_SRC: begin
                o_cmd.op = (lim == '0) ? rct_pkg::OP_LIST_NONE : rct_pkg::OP_LIST_SRC;
            end
            default: begin
                o_cmd.op = (lim == '0) ? rct_pkg::OP_LIST_NONE : rct_pkg::OP_LIST_DST;
            end
        endcase
    end

endmodule

FILE: rtl/rct_queue.sv
// Short command queue between front end and table engine.
// Depends on rct_pkg.
module rct_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rct_pkg::t_cmd i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_vld,
    output rct_pkg::t_cmd o_data
);

    localparam int PW = $clog2(rct_pkg::QDEPTH);
    localparam int CW = $clog2(rct_pkg::QDEPTH + 1);

    rct_pkg::t_cmd r_mem [rct_pkg::QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full = (r_cnt == CW'(rct_pkg::QDEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(rct_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(rct_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

endmodule

FILE: rtl/rct_back.sv
// Table engine: slot store, valid bits, active count and the slot scan
// that serves add and list operations. Depends on rct_pkg.
module rct_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_vld,
    input  rct_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    output rct_pkg::t_result o_res
);

    localparam int SW = rct_pkg::SLOT_W;
    localparam int CW = rct_pkg::CNT_W;

    rct_pkg::t_state  r_state, n_state;
    rct_pkg::t_entry  r_mem [rct_pkg::SLOTS];
    rct_pkg::t_entry  r_rd_ent;
    logic [rct_pkg::SLOTS-1:0] r_valid;
    logic [CW-1:0]    r_addr;
    logic             r_rd_go;
    logic [SW-1:0]    r_rd_idx;
    logic [CW-1:0]    r_active, n_active;
    logic             r_dup_hit, r_free_hit, r_held_vld;
    logic [SW-1:0]    r_dup_idx, r_free_idx, r_held_idx;
    logic [7:0]       r_dup_ty;
    rct_pkg::t_entry  r_held_ent;
    logic [6:0]       r_nlist;
    rct_pkg::t_result r_out, n_out;

    logic             is_list, add_match, list_match, scan_end;
    logic             mem_we, set_en, clr_en;
    logic [SW-1:0]    mem_wa, vld_idx;
    rct_pkg::t_entry  mem_wd;
    logic [3:0]       key;

    assign is_list  = (i_cmd.op == rct_pkg::OP_LIST_SRC) || (i_cmd.op == rct_pkg::OP_LIST_DST);
    assign key      = (i_cmd.op == rct_pkg::OP_LIST_SRC) ? r_rd_ent.sc : r_rd_ent.dc;
    assign add_match = r_rd_go && r_valid[r_rd_idx]
        && (r_rd_ent.sc == i_cmd.ent.sc) && (r_rd_ent.sn == i_cmd.ent.sn)
        && (r_rd_ent.dc == i_cmd.ent.dc) && (r_rd_ent.dn == i_cmd.ent.dn);
    assign list_match = r_rd_go && is_list && r_valid[r_rd_idx]
        && (key == i_cmd.qc) && (r_nlist < i_cmd.lim);
    assign scan_end = (r_addr == CW'(rct_pkg::SLOTS)) && !r_rd_go;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rct_pkg::S_IDLE: begin
                if (i_cmd_vld) begin
                    n_state = (is_list || (i_cmd.op == rct_pkg::OP_ADD))
                        ? rct_pkg::S_SCAN : rct_pkg::S_DONE;
                end
            end
            rct_pkg::S_SCAN: begin
                if (scan_end) begin
                    n_state = rct_pkg::S_DONE;
                end
            end
            default: begin
                n_state = rct_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out    = '0;
        n_active = r_active;
        mem_we   = 1'b0;
        mem_wa   = '0;
        mem_wd   = i_cmd.ent;
        set_en   = 1'b0;
        clr_en   = 1'b0;
        vld_idx  = '0;
        o_pop    = 1'b0;
        if (r_state == rct_pkg::S_SCAN && list_match && r_held_vld) begin
            n_out.vld    = 1'b1;
            n_out.status = rct_pkg::ST_LISTED;
            n_out.slot   = 6'(r_held_idx);
            n_out.ent    = r_held_ent;
        end
        if (r_state == rct_pkg::S_DONE) begin
            o_pop      = 1'b1;
            n_out.vld  = 1'b1;
            n_out.last = 1'b1;
            unique case (i_cmd.op)
                rct_pkg::OP_ADD_BAD: begin
                    n_out.status = rct_pkg::ST_INVALID;
                end
                rct_pkg::OP_ADD: begin
                    if (r_dup_hit) begin
                        mem_we       = 1'b1;
                        mem_wa       = r_dup_idx;
                        mem_wd.ty    = r_dup_ty;
                        n_out.status = rct_pkg::ST_UPDATED;
                        n_out.slot   = 6'(r_dup_idx);
                    end else if (r_free_hit) begin
                        mem_we       = 1'b1;
                        mem_wa       = r_free_idx;
                        set_en       = 1'b1;
                        vld_idx      = r_free_idx;
                        n_active     = r_active + 1'b1;
                        n_out.status = rct_pkg::ST_ADDED;
                        n_out.slot   = 6'(r_free_idx);
                    end else begin
                        n_out.status = rct_pkg::ST_FULL;
                    end
                end
                rct_pkg::OP_REMOVE: begin
                    n_out.slot = i_cmd.idx;
                    if ({1'b0, i_cmd.idx} < 7'(rct_pkg::SLOTS) && r_valid[SW'(i_cmd.idx)]) begin
                        clr_en       = 1'b1;
                        vld_idx      = SW'(i_cmd.idx);
                        n_active     = r_active - 1'b1;
                        n_out.status = rct_pkg::ST_REMOVED;
                    end else begin
                        n_out.status = rct_pkg::ST_IGNORED;
                    end
                end
                rct_pkg::OP_LIST_SRC, rct_pkg::OP_LIST_DST: begin
                    if (r_held_vld) begin
                        n_out.status = rct_pkg::ST_LISTED;
                        n_out.slot   = 6'(r_held_idx);
                        n_out.ent    = r_held_ent;
                    end else begin
                        n_out.status = rct_pkg::ST_EMPTY;
                    end
                end
                default: begin
                    n_out.status = rct_pkg::ST_EMPTY;
                end
            endcase
        end
        n_out.active = n_active;
    end

    always_ff @(posedge i_clk) begin
        r_rd_ent <= r_mem[r_addr[SW-1:0]];
        r_rd_idx <= r_addr[SW-1:0];
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (list_match) begin
            r_held_idx <= r_rd_idx;
            r_held_ent <= r_rd_ent;
        end
        if (add_match && !r_dup_hit) begin
            r_dup_idx <= r_rd_idx;
            r_dup_ty  <= r_rd_ent.ty;
        end
        if (r_rd_go && !r_valid[r_rd_idx] && !r_free_hit) begin
            r_free_idx <= r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rct_pkg::S_IDLE;
            r_valid    <= '0;
            r_active   <= '0;
            r_addr     <= '0;
            r_rd_go    <= 1'b0;
            r_dup_hit  <= 1'b0;
            r_free_hit <= 1'b0;
            r_held_vld <= 1'b0;
            r_nlist    <= '0;
            r_out      <= '0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_out    <= n_out;
            r_rd_go  <= (r_state == rct_pkg::S_SCAN) && (r_addr < CW'(rct_pkg::SLOTS));
            if (set_en) begin
                r_valid[vld_idx] <= 1'b1;
            end
            if (clr_en) begin
                r_valid[vld_idx] <= 1'b0;
            end
            if (r_state == rct_pkg::S_IDLE) begin
                r_addr     <= '0;
                r_dup_hit  <= 1'b0;
                r_free_hit <= 1'b0;
                r_held_vld <= 1'b0;
                r_nlist    <= '0;
            end else begin
                if (r_addr < CW'(rct_pkg::SLOTS)) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (add_match) begin
                    r_dup_hit <= 1'b1;
                end
                if (r_rd_go && !r_valid[r_rd_idx]) begin
                    r_free_hit <= 1'b1;
                end
                if (list_match) begin
                    r_held_vld <= 1'b1;
                    r_nlist    <= r_nlist + 1'b1;
                end
            end
        end
    end

    assign o_res = r_out;

endmodule

FILE: rtl/route_connection_table_top.sv
// Top level of the route connection table.
// Depends on rct_pkg, rct_front, rct_queue and rct_back.
//
// Usage: drive a command beat with start high; it is taken on a rising
// edge where start is high and busy is low. busy rises when the two-entry
// command queue is full. Results appear one per cycle on the o_ ports,
// marked by o_valid for exactly one cycle; o_last marks the final result
// of a command. The receiver cannot hold results off.
// Flow: a taken command is stored in the queue and reaches its head once
// the commands ahead of it are done. Invalid adds, removes and zero-limit
// lists go from the head straight to the done state and their result is
// registered from it; the engine takes the next command in the cycle that
// result appears. Adds and lists scan all 64 slots through the slot
// memory's single registered read port, one slot per cycle, and give their
// final result after the scan; the engine takes no new command until then.
// List results stream out during the scan, the final one after it.
// Reset: synchronous, active low; all slots read as free and the active
// count is zero at once, with no clearing pass.
module route_connection_table_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [1:0]         i_kind,
    input  logic [3:0]         i_src_chain,
    input  logic [3:0]         i_src_node,
    input  logic [3:0]         i_dst_chain,
    input  logic [3:0]         i_dst_node,
    input  logic signed [15:0] i_route_weight,
    input  logic [7:0]         i_type_id,
    input  logic               i_endpoints_ok,
    input  logic [5:0]         i_route_index,
    input  logic [3:0]         i_query_chain,
    input  logic [6:0]         i_list_limit,
    output logic               busy,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [5:0]         o_slot,
    output logic [3:0]         o_out_src_chain,
    output logic [3:0]         o_out_src_node,
    output logic [3:0]         o_out_dst_chain,
    output logic [3:0]         o_out_dst_node,
    output logic signed [15:0] o_out_weight,
    output logic [7:0]         o_out_type_id,
    output logic [6:0]         o_active_routes,
    output logic               o_last
);

    logic             push, pop, full, q_vld;
    rct_pkg::t_cmd    f_cmd, q_cmd;
    rct_pkg::t_result res;

    rct_front u_front (
        .i_start        (start),
        .i_full         (full),
        .i_kind         (i_kind),
        .i_src_chain    (i_src_chain),
        .i_src_node     (i_src_node),
        .i_dst_chain    (i_dst_chain),
        .i_dst_node     (i_dst_node),
        .i_route_weight (i_route_weight),
        .i_type_id      (i_type_id),
        .i_endpoints_ok (i_endpoints_ok),
        .i_route_index  (i_route_index),
        .i_query_chain  (i_query_chain),
        .i_list_limit   (i_list_limit),
        .o_push         (push),
        .o_cmd          (f_cmd)
    );

    rct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_vld   (q_vld),
        .o_data  (q_cmd)
    );

    rct_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (q_vld),
        .i_cmd     (q_cmd),
        .o_pop     (pop),
        .o_res     (res)
    );

    assign busy            = full;
    assign o_valid         = res.vld;
    assign o_status        = res.status;
    assign o_slot          = res.slot;
    assign o_out_src_chain = res.ent.sc;
    assign o_out_src_node  = res.ent.sn;
    assign o_out_dst_chain = res.ent.dc;
    assign o_out_dst_node  = res.ent.dn;
    assign o_out_weight    = res.ent.w;
    assign o_out_type_id   = res.ent.ty;
    assign o_active_routes = res.active;
    assign o_last          = res.last;

endmodule

FILE: rtl/rct_checker.sv
// Port-level checks of the route connection table, bound to the top level.
// Depends on rct_pkg and route_connection_table_top.
module rct_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               busy,
    input logic               o_valid,
    input logic [2:0]         o_status,
    input logic [3:0]         o_out_src_chain,
    input logic [3:0]         o_out_dst_chain,
    input logic signed [15:0] o_out_weight,
    input logic [7:0]         o_out_type_id,
    input logic [6:0]         o_active_routes,
    input logic               o_last
);

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != rct_pkg::ST_LISTED) |-> o_last)
        else $error("non-list result without last");

    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != rct_pkg::ST_LISTED) |->
        (o_out_src_chain == '0 && o_out_dst_chain == '0 &&
         o_out_weight == '0 && o_out_type_id == '0))
        else $error("route fields set outside a listing");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_active_routes <= 7'(rct_pkg::SLOTS)))
        else $error("active count out of range");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !busy))
        else $error("activity straight after reset");

endmodule

bind route_connection_table_top rct_checker u_rct_checker (.*);
